[hw/rtl/jas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jas_pkg: shared types and constants for the joystick axis shaper
// Beat payloads, configuration set, register indexes, operation codes and
// response curve constants.
// ----------------------------------------------------------------------------
package jas_pkg;

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_DEAD_ZONE = 2'd0,
		REG_X_OFFSET  = 2'd1,
		REG_Y_OFFSET  = 2'd2,
		REG_TIMEOUT   = 2'd3
	} reg_idx_t;

	// reset values
	localparam logic [7:0] TIMEOUT_RESET = 8'd22;

	// response curve
	localparam logic [6:0] LOW_THRESH  = 7'd60;
	localparam logic [6:0] MID_THRESH  = 7'd100;
	localparam logic [6:0] AXIS_MAX    = 7'd127;
	// 171 / 2048 approximates 1/12, exact floor for magnitudes below 60
	localparam logic [7:0] RECIP12       = 8'd171;
	localparam int         RECIP12_SHIFT = 11;
	localparam int         MID_SHIFT     = 3;

	typedef struct packed {
		logic              operation;
		logic signed [7:0] sample_x;
		logic signed [7:0] sample_y;
		logic [7:0]        elapsed_ms;
		logic              button_level;
	} in_beat_t;

	typedef struct packed {
		logic signed [7:0] shaped_x;
		logic signed [7:0] shaped_y;
		logic              button_pressed;
	} out_beat_t;

	typedef struct packed {
		logic [6:0]        dead_zone;
		logic signed [7:0] x_offset;
		logic signed [7:0] y_offset;
		logic [7:0]        recentre_timeout;
	} cfg_t;

endpackage
`default_nettype wire

[hw/rtl/jas_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jas_regs: configuration register file
// APB-style write and read of the four shaper registers.
// ----------------------------------------------------------------------------
module jas_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output jas_pkg::cfg_t    cfg
);

	jas_pkg::cfg_t    cfg_q;
	jas_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = jas_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone        <= '0;
			cfg_q.x_offset         <= '0;
			cfg_q.y_offset         <= '0;
			cfg_q.recentre_timeout <= jas_pkg::TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				jas_pkg::REG_DEAD_ZONE: cfg_q.dead_zone        <= pwdata[6:0];
				jas_pkg::REG_X_OFFSET:  cfg_q.x_offset         <= pwdata[7:0];
				jas_pkg::REG_Y_OFFSET:  cfg_q.y_offset         <= pwdata[7:0];
				jas_pkg::REG_TIMEOUT:   cfg_q.recentre_timeout <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			jas_pkg::REG_DEAD_ZONE: prdata = {25'd0, cfg_q.dead_zone};
			jas_pkg::REG_X_OFFSET:  prdata = {{24{cfg_q.x_offset[7]}}, cfg_q.x_offset};
			jas_pkg::REG_Y_OFFSET:  prdata = {{24{cfg_q.y_offset[7]}}, cfg_q.y_offset};
			jas_pkg::REG_TIMEOUT:   prdata = {24'd0, cfg_q.recentre_timeout};
			default:                prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/jas_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jas_lane: one axis shaping lane
// Dead zone, offset, clamp to +/-127 and the piecewise sensitivity curve.
// ----------------------------------------------------------------------------
module jas_lane (
	input  wire logic signed [7:0] position,
	input  wire logic [6:0]        dead_zone,
	input  wire logic signed [7:0] offset,
	output logic signed [7:0]      shaped
);

	logic signed [9:0] p_w;
	logic signed [9:0] d_w;
	logic signed [9:0] o_w;
	logic signed [9:0] v_w;
	logic signed [9:0] neg_v;
	logic signed [9:0] max_w;
	logic              pos;
	logic              in_dz;
	logic [6:0]        mag;
	logic [14:0]       prod;
	logic [6:0]        curve;

	// offset and clamp, worked on the magnitude
	always_comb begin
		p_w   = 10'(position);
		d_w   = $signed({3'b000, dead_zone});
		o_w   = 10'(offset);
		max_w = $signed({3'b000, jas_pkg::AXIS_MAX});
		pos   = (position > 8'sd0);
		in_dz = pos ? (p_w < d_w) : (p_w > -d_w);
		v_w   = pos ? (p_w - d_w + o_w) : (p_w + d_w + o_w);
		neg_v = -v_w;
		mag   = '0;
		if (in_dz) begin
			mag = '0;
		end else if (pos) begin
			priority if (v_w < 10'sd0) mag = '0;
			else if (v_w > max_w)      mag = jas_pkg::AXIS_MAX;
			else                       mag = v_w[6:0];
		end else begin
			priority if (v_w > 10'sd0) mag = '0;
			else if (neg_v > max_w)    mag = jas_pkg::AXIS_MAX;
			else                       mag = neg_v[6:0];
		end
	end

	// sensitivity curve: /12 for small, /8 for medium, straight above
	always_comb begin
		prod  = {8'd0, mag} * {7'd0, jas_pkg::RECIP12};
		curve = mag;
		priority if (mag < jas_pkg::LOW_THRESH) curve = 7'(prod >> jas_pkg::RECIP12_SHIFT);
		else if (mag < jas_pkg::MID_THRESH)     curve = mag >> jas_pkg::MID_SHIFT;
		else                                    curve = mag;
	end

	assign shaped = pos ? $signed({1'b0, curve}) : -$signed({1'b0, curve});

endmodule
`default_nettype wire

[hw/rtl/joystick_axis_shaper_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_axis_shaper_top: two-axis joystick dead zone and response curve
// Position and idle timer, X and Y shaping lanes, merge and output register.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while in_ready is high and returns one result beat
// per input beat (update stage, then lanes into the output register).
// A sample beat stores X/Y and clears the idle timer; a tick beat adds
// elapsed_ms to the saturating idle timer, recentres the position once the
// timer passes recentre_timeout, and latches the inverted button level. The X
// and Y lanes shape the stored position in parallel. in_ready drops only while
// both pipeline stages hold beats and out_ready is low.
module joystick_axis_shaper_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire jas_pkg::in_beat_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output jas_pkg::out_beat_t     out_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	jas_pkg::cfg_t      cfg;
	jas_pkg::out_beat_t merged;

	logic signed [7:0] pos_x_q, pos_y_q;
	logic [7:0]        idle_q;
	logic              btn_q;

	logic signed [7:0] pos_x_nxt, pos_y_nxt;
	logic [7:0]        idle_nxt;
	logic              btn_nxt;
	logic [8:0]        idle_sum;
	logic [7:0]        idle_sat;

	logic              valid_s1, valid_s2;
	logic signed [7:0] pos_x_s1, pos_y_s1;
	logic              btn_s1;
	jas_pkg::out_beat_t out_s2;

	logic accept, advance, s1_ready;
	logic signed [7:0] shaped_x, shaped_y;

	jas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake and stall
	assign advance  = !valid_s2 || out_ready;
	assign s1_ready = !valid_s1 || advance;
	assign in_ready = s1_ready;
	assign accept   = in_valid && in_ready;

	// next position, idle timer and button
	always_comb begin
		idle_sum  = {1'b0, idle_q} + {1'b0, in_data.elapsed_ms};
		idle_sat  = idle_sum[8] ? 8'hFF : idle_sum[7:0];
		pos_x_nxt = pos_x_q;
		pos_y_nxt = pos_y_q;
		idle_nxt  = idle_q;
		btn_nxt   = btn_q;
		if (in_data.operation == jas_pkg::OP_SAMPLE) begin
			pos_x_nxt = in_data.sample_x;
			pos_y_nxt = in_data.sample_y;
			idle_nxt  = '0;
		end else begin
			btn_nxt  = ~in_data.button_level;
			idle_nxt = idle_sat;
			if (idle_sat > cfg.recentre_timeout) begin
				pos_x_nxt = '0;
				pos_y_nxt = '0;
				idle_nxt  = '0;
			end
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			idle_q  <= '0;
			btn_q   <= 1'b0;
		end else if (accept) begin
			pos_x_q <= pos_x_nxt;
			pos_y_q <= pos_y_nxt;
			idle_q  <= idle_nxt;
			btn_q   <= btn_nxt;
		end
	end

	// stage 1: snapshot of the updated state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_x_s1 <= pos_x_nxt;
			pos_y_s1 <= pos_y_nxt;
			btn_s1   <= btn_nxt;
		end
	end

	// shaping lanes
	jas_lane u_lane_x (
		.position  (pos_x_s1),
		.dead_zone (cfg.dead_zone),
		.offset    (cfg.x_offset),
		.shaped    (shaped_x)
	);

	jas_lane u_lane_y (
		.position  (pos_y_s1),
		.dead_zone (cfg.dead_zone),
		.offset    (cfg.y_offset),
		.shaped    (shaped_y)
	);

	// merge lanes with the button into one result beat
	always_comb begin
		merged.shaped_x       = shaped_x;
		merged.shaped_y       = shaped_y;
		merged.button_pressed = btn_s1;
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_s2 <= merged;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	// checks
	a_sample_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.operation == jas_pkg::OP_SAMPLE |=> idle_q == 8'd0)
		else $error("idle timer not cleared by sample");

	a_no_min_code_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.shaped_x != 8'sh80)
		else $error("shaped_x out of range");

	a_no_min_code_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.shaped_y != 8'sh80)
		else $error("shaped_y out of range");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(pos_x_s1) && $stable(pos_y_s1))
		else $error("stage 1 beat lost during stall");

endmodule
`default_nettype wire
